// ----- sv/cafc_pkg.sv -----
// cafc_pkg: types, widths and a helper function for the com acceleration block
// no dependencies

package cafc_pkg;

  localparam int F       = 16;
  localparam int W       = 32;
  localparam int DW      = W + 1;
  localparam int MASS_W  = 31;
  localparam int TINY_W  = 16;
  localparam int PF_W    = 2 * W - F;
  localparam int PD_W    = 2 * W + 1 - F;
  localparam int NUM_W   = PF_W + 2;
  localparam int DEN_W   = PD_W + 2;
  localparam int DLO_W   = 32;
  localparam int DHI_W   = DEN_W - DLO_W;
  localparam int DP_W    = DEN_W + MASS_W;
  localparam int REM_W   = NUM_W + 2 * F;
  localparam int QW      = W + F;
  localparam int DVS_W   = DP_W + QW - 1;
  localparam int EREM_W  = W + F;
  localparam int EDVS_W  = MASS_W + QW - 1;
  localparam int ZP_W    = W + DW - F;
  localparam int ACC_W   = QW + 3;
  localparam int IDX_W   = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MASS   = 2'd1,
    ST_HEIGHT = 2'd2,
    ST_FORCE  = 2'd3
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MASS     = 3'd0,
    REG_GRAVITY  = 3'd1,
    REG_TINY     = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [MASS_W-1:0]   mass;
    logic [MASS_W-1:0]   gravity;
    logic [TINY_W-1:0]   tiny;
    logic [2:0][W-1:0]   normal;
  } cfg_t;

  typedef struct packed {
    logic [2:0][W-1:0] com;
    logic [2:0][W-1:0] zmp;
    logic [2:0][W-1:0] frc;
    logic [2:0][W-1:0] ext;
  } item_t;

  typedef struct packed {
    logic [2:0][DW-1:0] d;
    status_t            stat;
    logic               zok;
    logic               zneg;
    logic [2:0]         eneg;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]       zrem;
    logic [DVS_W-1:0]       zdvs;
    logic [QW-1:0]          zq;
    logic [2:0][EREM_W-1:0] erem;
    logic [EDVS_W-1:0]      edvs;
    logic [2:0][QW-1:0]     eq;
  } div_t;

  typedef struct packed {
    logic  valid;
    side_t side;
    div_t  div;
  } cell_t;

  // one restoring step on every lane
  function automatic div_t div_step(div_t x);
    div_t y;
    logic zge;
    logic ege;
    y = x;
    zge = {{(DVS_W-REM_W){1'b0}}, x.zrem} >= x.zdvs;
    if (zge) begin
      y.zrem = x.zrem - x.zdvs[REM_W-1:0];
    end
    y.zq = {x.zq[QW-2:0], zge};
    y.zdvs = x.zdvs >> 1;
    for (int i = 0; i < 3; i++) begin
      ege = {{(EDVS_W-EREM_W){1'b0}}, x.erem[i]} >= x.edvs;
      if (ege) begin
        y.erem[i] = x.erem[i] - x.edvs[EREM_W-1:0];
      end
      y.eq[i] = {x.eq[i][QW-2:0], ege};
    end
    y.edvs = x.edvs >> 1;
    return y;
  endfunction

endpackage

// ----- sv/cafc_front.sv -----
// cafc_front: difference, dot products, checks and divisor forming ahead of the divider
// depends on cafc_pkg

module cafc_front import cafc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  src_valid,
  input  item_t src,
  output cell_t cell_o
);

  logic [6:0] v;

  // stage 1
  item_t r1;

  // stage 2
  logic [2:0][DW-1:0] d2;
  logic [2:0][W-1:0]  f2;
  logic [2:0][W-1:0]  emag2;
  logic [2:0]         eneg2;

  // stage 3
  logic signed [PF_W-1:0] pf3 [3];
  logic signed [PD_W-1:0] pd3 [3];
  logic [2:0][DW-1:0]     d3;
  logic [2:0][W-1:0]      emag3;
  logic [2:0]             eneg3;
  status_t                stat3;

  // stage 4
  logic signed [NUM_W-1:0] num4;
  logic signed [DEN_W-1:0] den4;
  logic [2:0][DW-1:0]      d4;
  logic [2:0][W-1:0]       emag4;
  logic [2:0]              eneg4;
  status_t                 stat4;

  // stage 5
  logic [NUM_W-1:0]        nmag5;
  logic [DEN_W-1:0]        dmag5;
  side_t                   side5;
  logic [2:0][W-1:0]       emag5;

  // stage 6
  logic [NUM_W-1:0]          nmag6;
  logic [DLO_W+MASS_W-1:0]   plo6;
  logic [DHI_W+MASS_W-1:0]   phi6;
  side_t                     side6;
  logic [2:0][W-1:0]         emag6;

  // stage 7
  side_t side7;
  div_t  div7;

  logic signed [2*W-1:0] pf [3];
  logic signed [2*W:0]   pd [3];
  logic                  height_bad;
  status_t               stat_c;
  logic [DP_W-1:0]       dprod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i] = $signed(cfg.normal[i]) * $signed(f2[i]);
      pd[i] = $signed(cfg.normal[i]) * $signed(d2[i]);
    end
    height_bad = d2[2][DW-1] || (d2[2] == '0) || (d2[2] < DW'(cfg.tiny));
    priority if ((cfg.mass == '0) || (cfg.mass < MASS_W'(cfg.tiny))) begin
      stat_c = ST_MASS;
    end else if (height_bad) begin
      stat_c = ST_HEIGHT;
    end else if (f2[2][W-1]) begin
      stat_c = ST_FORCE;
    end else begin
      stat_c = ST_OK;
    end
    dprod = DP_W'(plo6) + (DP_W'(phi6) << DLO_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= src;

      for (int i = 0; i < 3; i++) begin
        d2[i]    <= {r1.com[i][W-1], r1.com[i]} - {r1.zmp[i][W-1], r1.zmp[i]};
        f2[i]    <= r1.frc[i];
        eneg2[i] <= r1.ext[i][W-1];
        emag2[i] <= r1.ext[i][W-1] ? (W'(0) - r1.ext[i]) : r1.ext[i];
      end

      for (int i = 0; i < 3; i++) begin
        pf3[i] <= PF_W'(pf[i] >>> F);
        pd3[i] <= PD_W'(pd[i] >>> F);
      end
      d3    <= d2;
      emag3 <= emag2;
      eneg3 <= eneg2;
      stat3 <= stat_c;

      num4  <= NUM_W'(pf3[0]) + NUM_W'(pf3[1]) + NUM_W'(pf3[2]);
      den4  <= DEN_W'(pd3[0]) + DEN_W'(pd3[1]) + DEN_W'(pd3[2]);
      d4    <= d3;
      emag4 <= emag3;
      eneg4 <= eneg3;
      stat4 <= stat3;

      nmag5      <= num4[NUM_W-1] ? (NUM_W'(0) - num4) : num4;
      dmag5      <= den4[DEN_W-1] ? (DEN_W'(0) - den4) : den4;
      side5.d    <= d4;
      side5.stat <= stat4;
      side5.zok  <= (stat4 == ST_OK) && (den4 != '0);
      side5.zneg <= num4[NUM_W-1] ^ den4[DEN_W-1];
      side5.eneg <= eneg4;
      emag5      <= emag4;

      nmag6 <= nmag5;
      plo6  <= dmag5[DLO_W-1:0] * cfg.mass;
      phi6  <= dmag5[DEN_W-1:DLO_W] * cfg.mass;
      side6 <= side5;
      emag6 <= emag5;

      side7     <= side6;
      div7.zrem <= {nmag6, {(2*F){1'b0}}};
      div7.zdvs <= {dprod, {(QW-1){1'b0}}};
      div7.zq   <= '0;
      for (int i = 0; i < 3; i++) begin
        div7.erem[i] <= {emag6[i], {F{1'b0}}};
        div7.eq[i]   <= '0;
      end
      div7.edvs <= {cfg.mass, {(QW-1){1'b0}}};
    end
  end

  assign cell_o = '{valid: v[6], side: side7, div: div7};

endmodule

// ----- sv/cafc_cell.sv -----
// cafc_cell: one divider cell, one quotient bit per lane per cycle while en is high
// depends on cafc_pkg

module cafc_cell import cafc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic  valid;
  side_t side;
  div_t  div;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= cell_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= cell_i.side;
      div  <= div_step(cell_i.div);
    end
  end

  assign cell_o = '{valid: valid, side: side, div: div};

endmodule

// ----- sv/cafc_back.sv -----
// cafc_back: zeta saturation, acceleration sum and output register
// depends on cafc_pkg

module cafc_back import cafc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  cell_t             cell_i,
  output logic              out_valid,
  output logic [2:0][W-1:0] acc,
  output logic [W-1:0]      zeta,
  output status_t           stat
);

  logic [1:0] v;

  // stage 1
  logic [W-1:0]          z1;
  logic [QW:0]           eq1 [3];
  logic [2:0][DW-1:0]    d1;
  status_t               stat1;

  // stage 2
  logic signed [ZP_W-1:0] zp2 [3];
  logic [QW:0]            eq2 [3];
  logic [W-1:0]           z2;
  status_t                stat2;

  logic [W-1:0]            zsat;
  logic [QW-1:0]           zq;
  logic signed [W+DW-1:0]  zp [3];
  logic signed [ACC_W-1:0] a [3];

  localparam logic signed [ACC_W-1:0] AMAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] AMIN = -ACC_W'(64'sh8000_0000);

  always_comb begin
    zq = cell_i.div.zq;
    if (!cell_i.side.zok) begin
      zsat = '0;
    end else if (cell_i.side.zneg) begin
      zsat = (zq > QW'(33'h0_8000_0000)) ? 32'h8000_0000 : (W'(0) - zq[W-1:0]);
    end else begin
      zsat = (zq > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : zq[W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      zp[i] = $signed(z1) * $signed(d1[i]);
      a[i] = ACC_W'(zp2[i]) + ACC_W'($signed(eq2[i]));
      if (i == 2) begin
        a[i] = a[i] - $signed({{(ACC_W-MASS_W){1'b0}}, cfg.gravity});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[0], cell_i.valid};
      out_valid <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1    <= zsat;
      d1    <= cell_i.side.d;
      stat1 <= cell_i.side.stat;
      for (int i = 0; i < 3; i++) begin
        eq1[i] <= cell_i.side.eneg[i] ? ((QW+1)'(0) - {1'b0, cell_i.div.eq[i]})
                                      : {1'b0, cell_i.div.eq[i]};
      end

      for (int i = 0; i < 3; i++) begin
        zp2[i] <= ZP_W'(zp[i] >>> F);
        eq2[i] <= eq1[i];
      end
      z2    <= z1;
      stat2 <= stat1;

      for (int i = 0; i < 3; i++) begin
        if (stat2 == ST_MASS) begin
          acc[i] <= '0;
        end else if (a[i] > AMAX) begin
          acc[i] <= 32'h7FFF_FFFF;
        end else if (a[i] < AMIN) begin
          acc[i] <= 32'h8000_0000;
        end else begin
          acc[i] <= a[i][W-1:0];
        end
      end
      zeta <= z2;
      stat <= stat2;
    end
  end

endmodule

// ----- sv/com_accel_from_contact_force.sv -----
// com_accel_from_contact_force: top level, config registers, input skid and divider chain
// depends on cafc_pkg, cafc_front, cafc_cell, cafc_back
// each accepted beat passes the front stages, the 48-cell divider chain and the back stages to its result
// throughput: one beat per cycle while the result is not stalled, one result per beat
// reset: clears all valid flags and the skid; config returns to its defaults

module com_accel_from_contact_force import cafc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [W-1:0]       wr_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] com_x,
  input  logic signed [31:0] com_y,
  input  logic signed [31:0] com_z,
  input  logic signed [31:0] zmp_x,
  input  logic signed [31:0] zmp_y,
  input  logic signed [31:0] zmp_z,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] ext_x,
  input  logic signed [31:0] ext_y,
  input  logic signed [31:0] ext_z,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] acc_x,
  output logic signed [31:0] acc_y,
  output logic signed [31:0] acc_z,
  output logic signed [31:0] zeta_squared,
  output logic [1:0]         status
);

  localparam int NCELL = QW;

  cfg_t  cfg;
  logic  en;
  logic  accept;
  logic  skid_v;
  item_t skid;
  item_t in_item;
  item_t src;
  logic  src_valid;

  cell_t chain [NCELL+1];

  logic [2:0][W-1:0] acc;
  logic [W-1:0]      zeta;
  status_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass    <= MASS_W'(65536);
      cfg.gravity <= MASS_W'(642689);
      cfg.tiny    <= TINY_W'(1);
      cfg.normal  <= {W'(65536), W'(0), W'(0)};
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MASS:     cfg.mass      <= wr_data[MASS_W-1:0];
        REG_GRAVITY:  cfg.gravity   <= wr_data[MASS_W-1:0];
        REG_TINY:     cfg.tiny      <= wr_data[TINY_W-1:0];
        REG_NORMAL_X: cfg.normal[0] <= wr_data;
        REG_NORMAL_Y: cfg.normal[1] <= wr_data;
        REG_NORMAL_Z: cfg.normal[2] <= wr_data;
        default: ;
      endcase
    end
  end

  assign en         = !(result_valid && result_stall);
  assign item_stall = skid_v;
  assign accept     = item_valid && !skid_v;

  assign in_item.com = {com_z, com_y, com_x};
  assign in_item.zmp = {zmp_z, zmp_y, zmp_x};
  assign in_item.frc = {force_z, force_y, force_x};
  assign in_item.ext = {ext_z, ext_y, ext_x};

  assign src       = skid_v ? skid : in_item;
  assign src_valid = skid_v || accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en) begin
      skid_v <= 1'b0;
    end else if (accept) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && accept) begin
      skid <= in_item;
    end
  end

  cafc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .src_valid (src_valid),
    .src       (src),
    .cell_o    (chain[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cafc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  cafc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .cell_i    (chain[NCELL]),
    .out_valid (result_valid),
    .acc       (acc),
    .zeta      (zeta),
    .stat      (stat)
  );

  assign acc_x        = acc[0];
  assign acc_y        = acc[1];
  assign acc_z        = acc[2];
  assign zeta_squared = zeta;
  assign status       = stat;

endmodule

// ----- sv/cafc_checker.sv -----
// cafc_checker: port-level assertions for the com acceleration block
// depends on cafc_pkg; bound to com_accel_from_contact_force

module cafc_checker import cafc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               wr_en,
  input logic [IDX_W-1:0]   wr_index,
  input logic [W-1:0]       wr_data,
  input logic               item_valid,
  input logic               item_stall,
  input logic signed [31:0] com_x,
  input logic signed [31:0] com_y,
  input logic signed [31:0] com_z,
  input logic signed [31:0] zmp_x,
  input logic signed [31:0] zmp_y,
  input logic signed [31:0] zmp_z,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic signed [31:0] force_z,
  input logic signed [31:0] ext_x,
  input logic signed [31:0] ext_y,
  input logic signed [31:0] ext_z,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] acc_x,
  input logic signed [31:0] acc_y,
  input logic signed [31:0] acc_z,
  input logic signed [31:0] zeta_squared,
  input logic [1:0]         status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("outputs not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(acc_x) && $stable(status))
    else $error("stalled result changed");

  a_mass_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_MASS) |->
      acc_x == 0 && acc_y == 0 && acc_z == 0 && zeta_squared == 0)
    else $error("bad mass result not zero");

  a_fail_zeta: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> zeta_squared == 0)
    else $error("zeta nonzero on failed check");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> $past(result_valid && result_stall))
    else $error("input stalled without output backpressure");

endmodule

bind com_accel_from_contact_force cafc_checker u_cafc_checker (.*);
